[rtl/bba_pkg.sv]
// Shared types and constants for the bitmap block allocator.
`default_nettype none

package bba_pkg;

    localparam int ADDR_W          = 48;
    localparam int IDX_OUT_W       = 6;
    localparam int S_DATA_W        = 48;
    localparam int M_DATA_W        = 56;
    localparam int NUM_BLOCKS_DEF  = 64;
    localparam int BLOCK_BYTES_DEF = 1048576;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_TEST,
        S_FREE_TEST,
        S_DONE
    } t_state;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

endpackage

`default_nettype wire

[rtl/bitmap_block_allocator.sv]
// Bitmap block allocator: top level with the scan sequencer and the shared adder.
// An allocate reads and tests one block flag at a time, in S_ALLOC_RD and then S_ALLOC_TEST.
// A free compares the address against one block boundary at a time in S_FREE_TEST.
// Both scans use the one shared 48-bit adder and the single-port flag memory.
// One item at a time; the next item can be accepted in the cycle after the result is taken.
// After reset a clearing pass marks every block free.
`default_nettype none

module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [ADDR_W-1:0]   i_cfg_wdata,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // address [47:0]
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    // action [0]
    input  wire logic                s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // result_address [47:0], from_pool [48], block_index [54:49], zero [55]
    output logic [M_DATA_W-1:0]      m_axis_tdata
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_BLOCKS - 1);
    localparam logic [ADDR_W-1:0] BB      = ADDR_W'(BLOCK_BYTES);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_k, n_k;
    logic [ADDR_W-1:0] r_acc, n_acc;
    logic [ADDR_W-1:0] r_off, n_off;
    logic [ADDR_W-1:0] r_pool_base;
    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    logic              r_from_pool, n_from_pool;
    logic [IDX_W-1:0]  r_res_idx, n_res_idx;

    logic [ADDR_W-1:0] add_a, add_b, add_sum;
    logic              add_cin;
    logic              mem_we, mem_wdata, mem_rdata;

    assign add_sum = add_a + add_b + ADDR_W'(add_cin);

    bba_flag_mem #(
        .DEPTH (NUM_BLOCKS),
        .IDX_W (IDX_W)
    ) u_flag_mem (
        .i_clk   (i_clk),
        .i_addr  (r_k),
        .i_we    (mem_we),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_k         <= '0;
            r_pool_base <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (i_cfg_we) begin
                r_pool_base <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc       <= n_acc;
        r_off       <= n_off;
        r_res_addr  <= n_res_addr;
        r_from_pool <= n_from_pool;
        r_res_idx   <= n_res_idx;
    end

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_acc       = r_acc;
        n_off       = r_off;
        n_res_addr  = r_res_addr;
        n_from_pool = r_from_pool;
        n_res_idx   = r_res_idx;
        add_a       = r_acc;
        add_b       = BB;
        add_cin     = 1'b0;
        mem_we      = 1'b0;
        mem_wdata   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = 1'b0;
                n_k       = r_k + 1'b1;
                if (r_k == LAST_IDX) begin
                    n_k     = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                add_a   = s_axis_tdata[ADDR_W-1:0];
                add_b   = ~r_pool_base;
                add_cin = 1'b1;
                if (s_axis_tvalid) begin
                    n_off       = add_sum;
                    n_k         = '0;
                    n_acc       = '0;
                    n_res_addr  = '0;
                    n_from_pool = 1'b0;
                    n_res_idx   = '0;
                    n_state     = (t_action'(s_axis_tuser) == ACT_FREE) ? S_FREE_TEST
                                                                       : S_ALLOC_RD;
                end
            end
            S_ALLOC_RD: begin
                n_state = S_ALLOC_TEST;
            end
            S_ALLOC_TEST: begin
                if (!mem_rdata) begin
                    add_b       = r_pool_base;
                    mem_we      = 1'b1;
                    mem_wdata   = 1'b1;
                    n_res_addr  = add_sum;
                    n_from_pool = 1'b1;
                    n_res_idx   = r_k;
                    n_state     = S_DONE;
                end else if (r_k == LAST_IDX) begin
                    n_state = S_DONE;
                end else begin
                    n_acc   = add_sum;
                    n_k     = r_k + 1'b1;
                    n_state = S_ALLOC_RD;
                end
            end
            S_FREE_TEST: begin
                if (r_off < add_sum) begin
                    mem_we      = 1'b1;
                    mem_wdata   = 1'b0;
                    n_from_pool = 1'b1;
                    n_res_idx   = r_k;
                    n_state     = S_DONE;
                end else if (r_k == LAST_IDX) begin
                    n_state = S_DONE;
                end else begin
                    n_acc = add_sum;
                    n_k   = r_k + 1'b1;
                end
            end
            S_DONE: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_DONE);
    assign m_axis_tdata  = {1'b0, IDX_OUT_W'(r_res_idx), r_from_pool, r_res_addr};

    // The block never takes a new item while a result is waiting.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // An accepted item starts work, so the input side closes on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready held after an item was accepted");

    // A miss or an outside address reports zero address and zero index.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[ADDR_W]) |->
        (m_axis_tdata[ADDR_W-1:0] == '0 && m_axis_tdata[ADDR_W+IDX_OUT_W:ADDR_W+1] == '0))
        else $error("non-zero payload on a result not served by the pool");

    // The flag memory is only written during clearing or on a decided hit.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLEAR || r_state == S_ALLOC_TEST || r_state == S_FREE_TEST))
        else $error("flag memory written outside the scan");

    // A result is held stable until it is taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("pending result changed before it was taken");

endmodule

`default_nettype wire

[rtl/bba_flag_mem.sv]
// Single-port memory of per-block used flags with a registered read.
`default_nettype none

module bba_flag_mem #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  wire logic             i_clk,
    input  wire logic [IDX_W-1:0] i_addr,
    input  wire logic             i_we,
    input  wire logic             i_wdata,
    output logic                  o_rdata
);

    logic r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

[tb/bitmap_block_allocator_test.sv]
// Self-checking testbench for the bitmap block allocator: directed and random items.
module bitmap_block_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bba_pkg::*;

    localparam int NUM_BLOCKS = NUM_BLOCKS_DEF;
    localparam logic [ADDR_W-1:0] BLOCK_SIZE = ADDR_W'(BLOCK_BYTES_DEF);
    localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};
    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic [ADDR_W-1:0]    address;
        logic                 from_pool;
        logic [IDX_OUT_W-1:0] index;
    } t_outcome;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [ADDR_W-1:0]     i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;

    logic [NUM_BLOCKS-1:0] free_map = '1;
    logic [ADDR_W-1:0]     pool_base = '0;
    t_outcome              outcomes_due[$];
    int                    failures = 0;
    int                    cycles = 0;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;

    bitmap_block_allocator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("bitmap_block_allocator regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Allocation takes the lowest free block; release maps the address onto the pool.
    function automatic t_outcome allocate_or_release(input t_action act,
                                                     input logic [ADDR_W-1:0] addr);
        t_outcome          o;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] blk;
        logic              found;
        o = '0;
        found = 1'b0;
        if (act == ACT_ALLOC) begin
            for (int b = 0; b < NUM_BLOCKS; b++) begin
                if (!found && free_map[b]) begin
                    found = 1'b1;
                    free_map[b] = 1'b0;
                    o.address = pool_base + ADDR_W'(b) * BLOCK_SIZE;
                    o.from_pool = 1'b1;
                    o.index = IDX_OUT_W'(b);
                end
            end
        end else begin
            offset = addr - pool_base;
            blk = offset / BLOCK_SIZE;
            if (blk < NUM_BLOCKS) begin
                free_map[blk] = 1'b1;
                o.from_pool = 1'b1;
                o.index = blk[IDX_OUT_W-1:0];
            end
        end
        return o;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (outcomes_due.size() == 0) begin
                $error("result with no item outstanding: tdata %h", m_axis_tdata);
                failures++;
            end else begin
                want = outcomes_due.pop_front();
                if (m_axis_tdata[47:0] !== want.address) begin
                    $error("result_address: expected %h, got %h",
                           want.address, m_axis_tdata[47:0]);
                    failures++;
                end
                if (m_axis_tdata[48] !== want.from_pool) begin
                    $error("from_pool: expected %b, got %b", want.from_pool, m_axis_tdata[48]);
                    failures++;
                end
                if (m_axis_tdata[54:49] !== want.index) begin
                    $error("block_index: expected %0d, got %0d",
                           want.index, m_axis_tdata[54:49]);
                    failures++;
                end
                if (m_axis_tdata[55] !== 1'b0) begin
                    $error("pad bit: expected 0, got %b", m_axis_tdata[55]);
                    failures++;
                end
            end
        end
    end

    task automatic send_request(input t_action act, input logic [ADDR_W-1:0] addr);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= addr;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        outcomes_due.push_back(allocate_or_release(act, addr));
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outcomes_due.size() != 0);
    endtask

    task automatic write_pool_base(input logic [ADDR_W-1:0] value);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        pool_base = value;
    endtask

    function automatic logic [ADDR_W-1:0] random_address();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] pick_pool_base();
        case ($urandom_range(4))
            0: return '0;
            1: return ALL_ONES;
            2: return ALL_ONES - ADDR_W'($urandom_range(NUM_BLOCKS - 2)) * BLOCK_SIZE
                       - ADDR_W'($urandom_range(255));
            3: return random_address() & ~(BLOCK_SIZE - 1);
            default: return random_address();
        endcase
    endfunction

    // Mostly blocks in use, with free blocks, near misses either side and wild addresses.
    function automatic logic [ADDR_W-1:0] pick_release_address();
        int                choice;
        int                used[$];
        logic [ADDR_W-1:0] offset;
        choice = $urandom_range(99);
        for (int b = 0; b < NUM_BLOCKS; b++) begin
            if (!free_map[b]) used.push_back(b);
        end
        offset = ADDR_W'($urandom_range(BLOCK_BYTES_DEF - 1));
        if (choice < 60 && used.size() > 0)
            return pool_base + ADDR_W'(used[$urandom_range(used.size() - 1)]) * BLOCK_SIZE
                   + offset;
        if (choice < 72)
            return pool_base + ADDR_W'($urandom_range(NUM_BLOCKS - 1)) * BLOCK_SIZE + offset;
        if (choice < 80)
            return pool_base - ADDR_W'($urandom_range(BLOCK_BYTES_DEF, 1));
        if (choice < 88)
            return pool_base + ADDR_W'(NUM_BLOCKS) * BLOCK_SIZE + offset;
        return random_address();
    endfunction

    task automatic test_alloc_and_free_basics();
        send_request(ACT_ALLOC, '0);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_FREE, 48'h0000_0008_00AB);
        send_request(ACT_FREE, 48'h0000_0008_00AB);
        send_request(ACT_FREE, 48'h0000_001F_FFFF);
        send_request(ACT_FREE, ADDR_W'(NUM_BLOCKS) * BLOCK_SIZE);
        send_request(ACT_FREE, ALL_ONES);
        send_request(ACT_ALLOC, ALL_ONES);
        send_request(ACT_FREE, '0);
    endtask

    task automatic test_wrapping_pool();
        logic [ADDR_W-1:0] base;
        base = ALL_ONES - 2 * BLOCK_SIZE + 1;
        write_pool_base(base);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_FREE, 48'h10);
        send_request(ACT_FREE, base - 1);
        send_request(ACT_FREE, base + ADDR_W'(NUM_BLOCKS) * BLOCK_SIZE - 1);
        send_request(ACT_FREE, base + ADDR_W'(NUM_BLOCKS) * BLOCK_SIZE);
    endtask

    task automatic test_base_rewrite();
        write_pool_base(ALL_ONES);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_FREE, '0);
        send_request(ACT_FREE, ALL_ONES - 1);
        send_request(ACT_ALLOC, '0);
        write_pool_base('0);
    endtask

    task automatic test_random_traffic(input int count);
        int sent;
        int alloc_pct;
        int run_left;
        sent = 0;
        run_left = 0;
        alloc_pct = 50;
        write_pool_base(pick_pool_base());
        while (sent < count) begin
            if (run_left == 0) begin
                run_left = $urandom_range(120, 40);
                case ($urandom_range(2))
                    0: alloc_pct = 85;
                    1: alloc_pct = 20;
                    default: alloc_pct = 50;
                endcase
                if ($urandom_range(2) == 0) write_pool_base(pick_pool_base());
            end
            if ($urandom_range(99) < alloc_pct) begin
                send_request(ACT_ALLOC, random_address());
            end else begin
                send_request(ACT_FREE, pick_release_address());
            end
            sent++;
            run_left--;
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 9;
        recv_stall_pct = 46;
        test_alloc_and_free_basics();
        test_wrapping_pool();
        test_base_rewrite();
        test_random_traffic(560);

        send_idle_pct  = 46;
        recv_stall_pct = 9;
        test_random_traffic(560);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(560);

        wait_for_results();
        repeat (200) @(posedge i_clk);
        if (failures == 0) begin
            $display("bitmap_block_allocator regression: pass");
        end else begin
            $display("bitmap_block_allocator regression: fail");
        end
        $finish;
    end

endmodule
